// File: hdl/hise_pkg.sv
`default_nettype none

package hise_pkg;

  // Fixed geometry of the set
  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned BUCKET_W  = 8;
  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned HALF_W    = 64;
  localparam int unsigned KEY_W     = 2 * HALF_W;
  localparam int unsigned MODE_W    = 2;

  // Operation codes; the unused code behaves as a query
  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage : hise_pkg

`default_nettype wire

// File: hdl/hise_if.sv
`default_nettype none

// Request channel: one set operation per transfer
interface hise_req_if;
  logic                           valid;
  logic                           ready;
  logic [hise_pkg::MODE_W-1:0]    mode;
  logic [hise_pkg::HALF_W-1:0]    key_low;
  logic [hise_pkg::HALF_W-1:0]    key_high;

  modport source (output valid, output mode, output key_low, output key_high, input ready);
  modport sink   (input valid, input mode, input key_low, input key_high, output ready);
endinterface : hise_req_if

// Response channel: one result per request
interface hise_rsp_if;
  logic valid;
  logic ready;
  logic was_present;
  logic status;

  modport source (output valid, output was_present, output status, input ready);
  modport sink   (input valid, input was_present, input status, output ready);
endinterface : hise_rsp_if

`default_nettype wire

// File: hdl/hashed_id_set_engine_top.sv
// The bucket row is read in the accept cycle and compared and written back in
// the following cycle, where the result is also registered for output.
// A new request is accepted only after the previous one has finished.
// A waiting result stalls the write-back cycle until it is taken.
// Reset (synchronous, active high) clears control state and the per-row
// written flags at once; no clearing pass is needed.
`default_nettype none

module hashed_id_set_engine_top #(
  parameter int unsigned WAYS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  hise_req_if.sink  req,
  hise_rsp_if.source rsp
);

  hise_pkg::state_t state;
  hise_pkg::state_t state_next;

  hise_pkg::mode_t                 mode_q;
  logic [hise_pkg::HALF_W-1:0]     key_low_q;
  logic [hise_pkg::HALF_W-1:0]     key_high_q;
  logic [hise_pkg::BUCKET_W-1:0]   bucket_q;
  logic [hise_pkg::BUCKET_W-1:0]   bucket;
  logic [hise_pkg::KEY_W-1:0]      key_q;

  logic [WAYS*hise_pkg::KEY_W-1:0] rd_keys;
  logic [WAYS-1:0]                 rd_valid;
  logic                            wr_en;
  logic [WAYS*hise_pkg::KEY_W-1:0] wr_keys;
  logic [WAYS-1:0]                 wr_valid;
  logic [WAYS-1:0]                 hit_mask;
  logic [WAYS-1:0]                 free_mask;

  logic req_fire;
  logic finish;
  logic hit;
  logic has_free;
  logic status_next;

  logic rsp_valid;
  logic was_present;
  logic status;

  assign req_fire = req.valid && req.ready;
  assign key_q    = {key_high_q, key_low_q};
  assign hit      = |hit_mask;
  assign has_free = |free_mask;

  hise_bucket_hash u_hash (
    .key_low  (req.key_low),
    .key_high (req.key_high),
    .bucket   (bucket)
  );

  hise_row_mem #(.WAYS(WAYS)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (req_fire),
    .rd_addr  (bucket),
    .rd_keys  (rd_keys),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (bucket_q),
    .wr_keys  (wr_keys),
    .wr_valid (wr_valid)
  );

  hise_way_match #(.WAYS(WAYS)) u_match (
    .row_keys  (rd_keys),
    .row_valid (rd_valid),
    .key       (key_q),
    .hit_mask  (hit_mask),
    .free_mask (free_mask)
  );

  // New row contents: insert fills the lowest free way, remove drops the hit
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_keys[w*hise_pkg::KEY_W +: hise_pkg::KEY_W] =
        free_mask[w] ? key_q : rd_keys[w*hise_pkg::KEY_W +: hise_pkg::KEY_W];
    end
  end

  // Sequencer: next state, write-back and result status
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    finish      = 1'b0;
    wr_en       = 1'b0;
    wr_valid    = rd_valid;
    status_next = hise_pkg::STATUS_DONE;
    unique case (state)
      hise_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = hise_pkg::ST_LOOKUP;
        end
      end
      hise_pkg::ST_LOOKUP: begin
        finish = !rsp_valid || rsp.ready;
        unique case (mode_q)
          hise_pkg::MODE_INSERT: begin
            if (!hit) begin
              if (has_free) begin
                wr_valid = rd_valid | free_mask;
                wr_en    = finish;
              end else begin
                status_next = hise_pkg::STATUS_FULL;
              end
            end
          end
          hise_pkg::MODE_REMOVE: begin
            if (hit) begin
              wr_valid = rd_valid & ~hit_mask;
              wr_en    = finish;
            end
          end
          default: begin
          end
        endcase
        if (finish) begin
          state_next = hise_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hise_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hise_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (req_fire) begin
      mode_q     <= hise_pkg::mode_t'(req.mode);
      key_low_q  <= req.key_low;
      key_high_q <= req.key_high;
      bucket_q   <= bucket;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      was_present <= hit;
      status      <= status_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.was_present = was_present;
  assign rsp.status      = status;

endmodule : hashed_id_set_engine_top

`default_nettype wire

// File: hdl/hise_bucket_hash.sv
`default_nettype none

// Bucket index: sum of the 16 key bytes modulo 256, as a four-level adder tree
module hise_bucket_hash (
  input  wire logic [hise_pkg::HALF_W-1:0]   key_low,
  input  wire logic [hise_pkg::HALF_W-1:0]   key_high,
  output logic      [hise_pkg::BUCKET_W-1:0] bucket
);

  logic [hise_pkg::KEY_W-1:0] key;
  logic [7:0] lvl0 [16];
  logic [7:0] lvl1 [8];
  logic [7:0] lvl2 [4];
  logic [7:0] lvl3 [2];

  assign key = {key_high, key_low};

  // 8-bit adds wrap, which gives the modulo for free
  always_comb begin
    for (int i = 0; i < 16; i++) lvl0[i] = key[8*i +: 8];
    for (int i = 0; i < 8; i++)  lvl1[i] = lvl0[2*i] + lvl0[2*i+1];
    for (int i = 0; i < 4; i++)  lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    for (int i = 0; i < 2; i++)  lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
    bucket = lvl3[0] + lvl3[1];
  end

endmodule : hise_bucket_hash

`default_nettype wire

// File: hdl/hise_row_mem.sv
`default_nettype none

// Bucket row store: WAYS keys plus WAYS valid bits per row.
// A per-row flag marks rows written since reset; an unwritten row reads as all invalid.
module hise_row_mem #(
  parameter int unsigned WAYS = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 rd_en,
  input  wire logic [hise_pkg::BUCKET_W-1:0]        rd_addr,
  output logic      [WAYS*hise_pkg::KEY_W-1:0]      rd_keys,
  output logic      [WAYS-1:0]                      rd_valid,
  input  wire logic                                 wr_en,
  input  wire logic [hise_pkg::BUCKET_W-1:0]        wr_addr,
  input  wire logic [WAYS*hise_pkg::KEY_W-1:0]      wr_keys,
  input  wire logic [WAYS-1:0]                      wr_valid
);

  localparam int unsigned ROW_W = WAYS * hise_pkg::KEY_W + WAYS;

  logic [ROW_W-1:0]             mem [hise_pkg::BUCKETS];
  logic [ROW_W-1:0]             rd_row;
  logic [hise_pkg::BUCKETS-1:0] row_init;
  logic                         rd_init;

  // Row array: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_keys, wr_valid};
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  // Row-written flags, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_init[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_init <= row_init[rd_addr];
      end
    end
  end

  assign rd_keys  = rd_row[ROW_W-1:WAYS];
  assign rd_valid = rd_init ? rd_row[WAYS-1:0] : '0;

endmodule : hise_row_mem

`default_nettype wire

// File: hdl/hise_way_match.sv
`default_nettype none

// Compares all ways of a row with the key; returns the lowest matching
// valid way and the lowest free way, each as a one-hot mask
module hise_way_match #(
  parameter int unsigned WAYS = 4
) (
  input  wire logic [WAYS*hise_pkg::KEY_W-1:0] row_keys,
  input  wire logic [WAYS-1:0]                 row_valid,
  input  wire logic [hise_pkg::KEY_W-1:0]      key,
  output logic      [WAYS-1:0]                 hit_mask,
  output logic      [WAYS-1:0]                 free_mask
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] empty;

  // Per-way compare
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_valid[w] && (row_keys[w*hise_pkg::KEY_W +: hise_pkg::KEY_W] == key);
    end
  end

  assign empty = ~row_valid;

  // Isolate the lowest set bit
  assign hit_mask  = match & (~match + WAYS'(1));
  assign free_mask = empty & (~empty + WAYS'(1));

endmodule : hise_way_match

`default_nettype wire
